[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is checked only outside reset.
`define ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/eec_pkg.sv]
// ----------------------------------------------------------------------------
// Elastic easing curve package
// Q30 types, polynomial constants, curve codes and the rounded Q30 multiply.
// ----------------------------------------------------------------------------
package eec_pkg;

  // Signed Q30 value with enough headroom for the sine polynomial.
  typedef logic signed [32:0] q30_t;
  // Wider signed Q30 value for the final combine (holds 8 times a product).
  typedef logic signed [35:0] yw_t;

  // Curve mode register codes.
  localparam logic [1:0] MODE_IN    = 2'd0;
  localparam logic [1:0] MODE_OUT   = 2'd1;
  localparam logic [1:0] MODE_INOUT = 2'd2;

  // Which piece of which curve an item evaluates.
  typedef enum logic [2:0] {
    KIND_IN,
    KIND_OUT,
    KIND_LO,
    KIND_MID,
    KIND_HI
  } kind_t;

  // Odd Taylor coefficients of sin(2*pi*u/4) in Q30.
  localparam q30_t SIN_C1 = 33'sd1686629713;
  localparam q30_t SIN_C3 = 33'sd693598669;
  localparam q30_t SIN_C5 = 33'sd85569306;
  localparam q30_t SIN_C7 = 33'sd5026995;
  localparam q30_t SIN_C9 = 33'sd172272;
  localparam q30_t Q30_THREE_QUARTERS = 33'sd805306368;
  localparam yw_t  Y_ONE  = 36'sd1073741824;
  localparam yw_t  Y_HALF = 36'sd536870912;

  // Payload of one pipeline stage.
  typedef struct packed {
    kind_t kind;
    logic  sneg;
    q30_t  u30;
    q30_t  xp;
    q30_t  z;
    q30_t  p;
  } stage_t;

  // Q30 multiply, magnitude rounded to nearest with halves away from zero.
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pr;
    logic [33:0] r;
    neg = a[32] ^ b[32];
    ma  = a[32] ? 32'(-a) : 32'(a);
    mb  = b[32] ? 32'(-b) : 32'(b);
    pr  = 64'(ma) * 64'(mb);
    r   = 34'((pr + (64'(1) << 29)) >> 30);
    return neg ? -q30_t'(r) : q30_t'(r);
  endfunction

endpackage

[design/eec_if.sv]
// ----------------------------------------------------------------------------
// Elastic easing curve channels
// Valid/ready channels for progress samples and eased results.
// ----------------------------------------------------------------------------
interface eec_in_if #(parameter int W = 17);
  logic         valid;
  logic         ready;
  logic [W-1:0] progress;
  modport source (output valid, output progress, input ready);
  modport sink   (input valid, input progress, output ready);
endinterface

interface eec_out_if #(parameter int W = 19);
  logic         valid;
  logic         ready;
  logic [W-1:0] eased_value;
  modport source (output valid, output eased_value, input ready);
  modport sink   (input valid, input eased_value, output ready);
endinterface

[design/elastic_easing_curve.sv]
// ----------------------------------------------------------------------------
// Elastic easing curve
// Maps progress t (unsigned Q1.F) to an elastic ease-in, ease-out or
// ease-in-out value (signed Q2.F, saturated to -1.0 .. 2.0).
//
//   Channel   Dir  Payload             Width
//   req       in   progress            FRAC_BITS+1
//   rsp       out  eased_value         FRAC_BITS+3
//   cfg       in   cfg_wr_data (mode)  2
//
// One item per cycle while rsp is not stalled; the pipeline holds an input fold
// stage, the multiplier stages of the sine polynomial, then combine and rounding stages.
// Reset clears the valid bits and sets the mode to ease-in.
// A stall on rsp freezes the whole pipeline; req.ready follows it.
// ----------------------------------------------------------------------------
module elastic_easing_curve
  import eec_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  eec_in_if.sink     req,
  eec_out_if.source  rsp
);

  localparam int TW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 2;
  localparam int OW = FRAC_BITS + 3;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic [TW-1:0] T_ONE  = TW'(1) << FRAC_BITS;
  localparam logic [TW+4:0] LO_LIM = (TW+5)'(9) << FRAC_BITS;
  localparam logic [TW+4:0] HI_LIM = (TW+5)'(11) << FRAC_BITS;
  localparam logic [PW-1:0] QTURN  = PW'(1) << FRAC_BITS;
  localparam yw_t RND    = yw_t'(1) << (29 - FRAC_BITS);
  localparam yw_t OUT_MX = yw_t'(2) << FRAC_BITS;
  localparam yw_t OUT_MN = -(yw_t'(1) << FRAC_BITS);

  logic [1:0]    curve_mode;
  logic [9:0]    vld;
  logic          ce;
  stage_t        s0, s1, s2, s3, s4, s5, s6, s7;
  yw_t           y8;
  logic [OW-1:0] eased;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= MODE_IN;
    end else if (cfg_wr_en) begin
      curve_mode <= cfg_wr_data;
    end
  end

  // The pipeline advances whenever the output register is free or drained.
  assign ce        = !vld[9] || rsp.ready;
  assign req.ready = ce;

  // Input fold: saturate t, pick curve piece, phase and power base.
  logic [TW-1:0]   t_sat, d_val, x_val;
  logic [TW+4:0]   t_ext, t20;
  logic [PW-1:0]   ph9, ph, off_full;
  logic [FRAC_BITS:0] u_val;
  kind_t           kind;

  always_comb begin
    t_sat = (req.progress > T_ONE) ? T_ONE : req.progress;
    d_val = T_ONE - t_sat;
    t_ext = (TW+5)'(t_sat);
    t20   = t_ext * (TW+5)'(20);
    ph9   = PW'(t_ext * (TW+5)'(9));
    unique case (curve_mode)
      MODE_IN:  kind = KIND_IN;
      MODE_OUT: kind = KIND_OUT;
      default: begin
        if (t20 < LO_LIM)      kind = KIND_LO;
        else if (t20 < HI_LIM) kind = KIND_MID;
        else                   kind = KIND_HI;
      end
    endcase
    case (kind)
      KIND_IN:  ph = ph9;
      KIND_OUT: ph = ph9 + QTURN;
      KIND_MID: ph = PW'(t_ext << 3);
      default:  ph = ph9 << 1;
    endcase
    x_val    = (kind == KIND_OUT || kind == KIND_HI) ? d_val : t_sat;
    off_full = ph & (QTURN - PW'(1));
    u_val    = ph[PW-2] ? (FRAC_BITS+1)'(QTURN - off_full)
                        : (FRAC_BITS+1)'(off_full);
  end

  // Next values of the data stages: squares, Horner steps of the sine, products.
  stage_t s0_next, s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next;
  always_comb begin
    s0_next      = '0;
    s0_next.kind = kind;
    s0_next.sneg = ph[PW-1];
    s0_next.u30  = q30_t'(u_val) << SH;
    s0_next.xp   = q30_t'(x_val) << SH;

    s1_next      = s0;
    s1_next.z    = mul_q30(s0.u30, s0.u30);
    s1_next.xp   = mul_q30(s0.xp, s0.xp);

    s2_next      = s1;
    s2_next.p    = mul_q30(SIN_C9, s1.z) - SIN_C7;
    s2_next.xp   = mul_q30(s1.xp, s1.xp);

    s3_next      = s2;
    s3_next.p    = SIN_C5 + mul_q30(s2.p, s2.z);

    s4_next      = s3;
    s4_next.p    = mul_q30(s3.p, s3.z) - SIN_C3;

    s5_next      = s4;
    s5_next.p    = SIN_C1 + mul_q30(s4.p, s4.z);

    s6_next      = s5;
    s6_next.p    = s5.sneg ? -mul_q30(s5.p, s5.u30) : mul_q30(s5.p, s5.u30);

    s7_next      = s6;
    s7_next.p    = mul_q30((s6.kind == KIND_MID) ? Q30_THREE_QUARTERS : s6.xp, s6.p);
  end

  // Final combine of the curve piece, in wide Q30.
  yw_t m_w, y_next;
  always_comb begin
    m_w = yw_t'(s7.p);
    case (s7.kind)
      KIND_IN:  y_next = m_w;
      KIND_OUT: y_next = Y_ONE - m_w;
      KIND_LO:  y_next = m_w <<< 3;
      KIND_MID: y_next = Y_HALF + m_w;
      default:  y_next = Y_ONE - (m_w <<< 3);
    endcase
  end

  // Rounding to Q.F and saturation.
  yw_t y_mag, y_rnd, y_sgn;
  always_comb begin
    y_mag = y8[35] ? -y8 : y8;
    y_rnd = (y_mag + RND) >>> SH;
    y_sgn = y8[35] ? -y_rnd : y_rnd;
    if (y_sgn < OUT_MN)      y_sgn = OUT_MN;
    else if (y_sgn > OUT_MX) y_sgn = OUT_MX;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[8:0], req.valid};
    end
  end

  // Data stages: squares, Horner steps of the sine, products, combine, round.
  always_ff @(posedge clk) begin
    if (ce) begin
      s0    <= s0_next;
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      s4    <= s4_next;
      s5    <= s5_next;
      s6    <= s6_next;
      s7    <= s7_next;
      y8    <= y_next;
      eased <= OW'(y_sgn);
    end
  end

  assign rsp.valid       = vld[9];
  assign rsp.eased_value = eased;

endmodule

[design/eec_checker.sv]
// ----------------------------------------------------------------------------
// Elastic easing curve checker
// Port-level checks on output range, flow control and reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eec_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [FRAC_BITS+2:0]   eased_value
);

  localparam int ONE = 1 << FRAC_BITS;

  logic signed [FRAC_BITS+2:0] ev;
  assign ev = eased_value;

  // A result always lies within -1.0 .. 2.0.
  `ASSERT_IMP(a_range, clk, rst, out_valid, (ev >= -ONE) && (ev <= 2 * ONE))
  // The input side is held back exactly when a result stalls.
  `ASSERT_IMP(a_flow, clk, rst, in_valid || !in_valid, in_ready == (!out_valid || out_ready))
  // A stalled result holds until its transfer.
  `ASSERT_IMP(a_hold, clk, rst, $past(out_valid && !out_ready) && !$past(rst), out_valid && $stable(eased_value))
  // Reset empties the pipeline.
  `ASSERT_NXT(a_reset, clk, rst, !out_valid)

endmodule

bind elastic_easing_curve eec_checker #(.FRAC_BITS(FRAC_BITS)) u_eec_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .eased_value (rsp.eased_value)
);
